### rtl/cmm_pkg.sv
// Shared constants, codes and types for the complex matrix multiplier.
// Used by cmm_store, cmm_mac and complex_matrix_multiply_core; depends on nothing.
package cmm_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DATA_WIDTH = 16;
    localparam int CELLS      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int FILL_W     = $clog2(CELLS + 1);
    localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W      = 4;
    localparam int ELEM_W     = 2 * DATA_WIDTH;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int ACC_W      = 40;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_START  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_ROWS = 2'd0,
        REG_A_COLS = 2'd1,
        REG_B_ROWS = 2'd2,
        REG_B_COLS = 2'd3
    } t_reg_idx;

    // Sideband that travels with each memory read through the MAC pipeline.
    typedef struct packed {
        logic first;     // first term of a dot product: restart the sum
        logic last_k;    // final term: the sum is a finished result
        logic last_all;  // final result of the whole run
    } t_tag;

    // Written values of 0 read as 1, values above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

### rtl/cmm_store.sv
// Element store for one matrix: one write port, one read port with registered data.
// Depends on cmm_pkg.
module cmm_store
    import cmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [ELEM_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [ELEM_W-1:0] o_rdata
);

    logic [ELEM_W-1:0] r_mem [CELLS];
    logic [ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read register holds while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cmm_mac.sv
// Complex multiply-accumulate pipeline: product stage, then the running sum.
// Depends on cmm_pkg; fed by two cmm_store read ports.
module cmm_mac
    import cmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_issue_v,
    input  t_tag              i_issue_tag,
    input  logic [ELEM_W-1:0] i_a_data,
    input  logic [ELEM_W-1:0] i_b_data,
    output logic              o_busy,
    output logic              o_res_valid,
    output logic              o_res_last,
    output logic [ACC_W-1:0]  o_res_re,
    output logic [ACC_W-1:0]  o_res_im
);

    logic        r_s1_v;
    logic        r_s2_v;
    t_tag        r_s1_tag;
    t_tag        r_s2_tag;

    logic signed [PROD_W-1:0] r_p_rr;
    logic signed [PROD_W-1:0] r_p_ii;
    logic signed [PROD_W-1:0] r_p_ri;
    logic signed [PROD_W-1:0] r_p_ir;
    logic        [ACC_W-1:0]  r_acc_re;
    logic        [ACC_W-1:0]  r_acc_im;

    logic signed [DATA_WIDTH-1:0] a_re, a_im, b_re, b_im;
    logic        [ACC_W-1:0]      term_re, term_im;
    logic        [ACC_W-1:0]      n_acc_re, n_acc_im;

    assign a_re = i_a_data[DATA_WIDTH-1:0];
    assign a_im = i_a_data[ELEM_W-1:DATA_WIDTH];
    assign b_re = i_b_data[DATA_WIDTH-1:0];
    assign b_im = i_b_data[ELEM_W-1:DATA_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (i_adv) begin
            r_s1_v <= i_issue_v;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_tag <= i_issue_tag;
            r_s2_tag <= r_s1_tag;
            r_p_rr   <= a_re * b_re;
            r_p_ii   <= a_im * b_im;
            r_p_ri   <= a_re * b_im;
            r_p_ir   <= a_im * b_re;
        end
    end

    always_comb begin
        term_re  = ACC_W'(r_p_rr) - ACC_W'(r_p_ii);
        term_im  = ACC_W'(r_p_ri) + ACC_W'(r_p_ir);
        n_acc_re = r_s2_tag.first ? term_re : r_acc_re + term_re;
        n_acc_im = r_s2_tag.first ? term_im : r_acc_im + term_im;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_s2_v) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
        end
    end

    assign o_busy      = r_s1_v || r_s2_v;
    assign o_res_valid = r_s2_v && r_s2_tag.last_k;
    assign o_res_last  = r_s2_tag.last_all;
    assign o_res_re    = n_acc_re;
    assign o_res_im    = n_acc_im;

endmodule

### rtl/complex_matrix_multiply_core.sv
// Complex matrix multiplier top level: request streams, size registers, sequencer.
// Depends on cmm_pkg, cmm_store and cmm_mac.
//
//  Channel   Direction  Handshake                   Contents
//  s_axis    in         s_axis_tvalid/tready        tuser: op; tdata: elem_re, elem_im
//  m_axis    out        m_axis_tvalid/tready        tuser: size_error; tlast: last;
//                                                   tdata: prod_re, prod_im
//  cfg       in         i_cfg_valid/o_cfg_ready     i_cfg_addr: register; i_cfg_data
//
// A load request writes one element into the A or B store, unless that store is full.
// A start request runs the sequencer, which issues one store read per cycle unless
// the output stalls: a_rows * b_cols * a_cols reads, the result of each dot product
// passing the store read, product and output registers after its last read. A size
// mismatch gives a single result, flagged by size_error. Requests are held off while
// a run is issued, a size error is pending or a run is still in the MAC pipeline. Reset
// (i_rst_n low, synchronous) empties the pipeline, zeroes both fill counts and sets all
// four size registers to 8; stored elements are not cleared. While a result waits in the
// output register and m_axis_tready is low, the whole read and MAC pipeline stands still.
module complex_matrix_multiply_core
    import cmm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Request stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [ELEM_W-1:0]      s_axis_tdata,   // [15:0] elem_re, [31:16] elem_im
    input  logic [1:0]             s_axis_tuser,   // [1:0] op
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [2*ACC_W-1:0]     m_axis_tdata,   // [39:0] prod_re, [79:40] prod_im
    output logic                   m_axis_tuser,   // [0] size_error
    output logic                   m_axis_tlast,
    // Size register writes.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [DIM_W-1:0]       i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ERR
    } t_state;

    t_state r_state, n_state;

    logic [DIM_W-1:0]  r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [FILL_W-1:0] r_fill_a, r_fill_b, n_fill_a, n_fill_b;

    // Loop indices and the store addresses they map to.
    logic [IDX_W-1:0]  r_i, r_j, r_k, n_i, n_j, n_k;
    logic [ADDR_W-1:0] r_ia, r_ib, r_row_a, n_ia, n_ib, n_row_a;

    // Output register.
    logic              r_out_v, n_out_v;
    logic [ACC_W-1:0]  r_out_re, r_out_im, n_out_re, n_out_im;
    logic              r_out_err, r_out_last, n_out_err, n_out_last;

    logic        accept;
    t_op         op;
    logic        adv;
    logic        we_a, we_b;
    logic        issue_v;
    t_tag        issue_tag;
    logic        k_last, j_last, i_last;
    logic        mac_busy, res_valid, res_last;
    logic [ACC_W-1:0]  res_re, res_im;
    logic [ELEM_W-1:0] a_data, b_data;

    assign op     = t_op'(s_axis_tuser);
    assign accept = s_axis_tvalid && s_axis_tready;
    // The pipeline moves whenever the output register is free or being emptied.
    assign adv    = !r_out_v || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE) && !mac_busy;
    assign o_cfg_ready   = 1'b1;

    // Size registers; the written value is clamped to 1..MAX_DIM.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= DIM_W'(MAX_DIM);
            r_a_cols <= DIM_W'(MAX_DIM);
            r_b_rows <= DIM_W'(MAX_DIM);
            r_b_cols <= DIM_W'(MAX_DIM);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_A_ROWS: r_a_rows <= clamp_dim(i_cfg_data);
                REG_A_COLS: r_a_cols <= clamp_dim(i_cfg_data);
                REG_B_ROWS: r_b_rows <= clamp_dim(i_cfg_data);
                REG_B_COLS: r_b_cols <= clamp_dim(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Loads stop writing once a store is full.
    assign we_a = accept && (op == OP_LOAD_A) && (r_fill_a < FILL_W'(CELLS));
    assign we_b = accept && (op == OP_LOAD_B) && (r_fill_b < FILL_W'(CELLS));

    cmm_store u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_fill_a[ADDR_W-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (adv),
        .i_raddr (r_ia),
        .o_rdata (a_data)
    );

    cmm_store u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_fill_b[ADDR_W-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (adv),
        .i_raddr (r_ib),
        .o_rdata (b_data)
    );

    // Position of the current read within the i, j, k loop nest.
    assign k_last = (DIM_W'(r_k) + DIM_W'(1)) == r_a_cols;
    assign j_last = (DIM_W'(r_j) + DIM_W'(1)) == r_b_cols;
    assign i_last = (DIM_W'(r_i) + DIM_W'(1)) == r_a_rows;

    assign issue_v            = (r_state == ST_RUN);
    assign issue_tag.first    = (r_k == '0);
    assign issue_tag.last_k   = k_last;
    assign issue_tag.last_all = k_last && j_last && i_last;

    cmm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_issue_v   (issue_v),
        .i_issue_tag (issue_tag),
        .i_a_data    (a_data),
        .i_b_data    (b_data),
        .o_busy      (mac_busy),
        .o_res_valid (res_valid),
        .o_res_last  (res_last),
        .o_res_re    (res_re),
        .o_res_im    (res_im)
    );

    always_comb begin
        n_state    = r_state;
        n_fill_a   = r_fill_a;
        n_fill_b   = r_fill_b;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_ia       = r_ia;
        n_ib       = r_ib;
        n_row_a    = r_row_a;
        n_out_v    = r_out_v && !m_axis_tready;
        n_out_re   = r_out_re;
        n_out_im   = r_out_im;
        n_out_err  = r_out_err;
        n_out_last = r_out_last;

        if (we_a) begin
            n_fill_a = r_fill_a + FILL_W'(1);
        end
        if (we_b) begin
            n_fill_b = r_fill_b + FILL_W'(1);
        end

        // A finished dot product from the MAC goes to the output register.
        if (adv && res_valid) begin
            n_out_v    = 1'b1;
            n_out_re   = res_re;
            n_out_im   = res_im;
            n_out_err  = 1'b0;
            n_out_last = res_last;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept && (op == OP_START)) begin
                    n_fill_a = '0;
                    n_fill_b = '0;
                    n_i      = '0;
                    n_j      = '0;
                    n_k      = '0;
                    n_ia     = '0;
                    n_ib     = '0;
                    n_row_a  = '0;
                    n_state  = (r_a_cols == r_b_rows) ? ST_RUN : ST_ERR;
                end
            end
            ST_RUN: begin
                if (adv) begin
                    if (!k_last) begin
                        n_k  = r_k + IDX_W'(1);
                        n_ia = r_ia + ADDR_W'(1);
                        n_ib = r_ib + ADDR_W'(r_b_cols);
                    end else if (!j_last) begin
                        n_k  = '0;
                        n_j  = r_j + IDX_W'(1);
                        n_ia = r_row_a;
                        n_ib = ADDR_W'(r_j) + ADDR_W'(1);
                    end else if (!i_last) begin
                        n_k     = '0;
                        n_j     = '0;
                        n_i     = r_i + IDX_W'(1);
                        n_row_a = r_row_a + ADDR_W'(r_a_cols);
                        n_ia    = r_row_a + ADDR_W'(r_a_cols);
                        n_ib    = '0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                // The pipeline is empty here, so the error result cannot collide.
                if (adv) begin
                    n_out_v    = 1'b1;
                    n_out_re   = '0;
                    n_out_im   = '0;
                    n_out_err  = 1'b1;
                    n_out_last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill_a <= '0;
            r_fill_b <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill_a <= n_fill_a;
            r_fill_b <= n_fill_b;
            r_out_v  <= n_out_v;
        end
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_ia       <= n_ia;
        r_ib       <= n_ib;
        r_row_a    <= n_row_a;
        r_out_re   <= n_out_re;
        r_out_im   <= n_out_im;
        r_out_err  <= n_out_err;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out_im, r_out_re};
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tlast  = r_out_last;

endmodule
